// ===== rtl/pcae_pkg.sv =====
// Shared constants, types and state codes for the pulse charge and amplitude extractor.
`timescale 1ns / 1ps
`default_nettype none

package pcae_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 14;
  localparam int FRAC_BITS   = 4;

  localparam int IDX_BITS    = $clog2(MAX_SAMPLES) + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int NUM_BITS    = SUM_BITS + FRAC_BITS;
  localparam int BL_BITS     = 10;
  localparam int WS_BITS     = 10;
  localparam int WE_BITS     = 11;
  localparam int CFG_BITS    = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam int BASE_BITS   = SAMPLE_BITS + FRAC_BITS;
  localparam int CHARGE_BITS = 29;
  localparam int AMP_BITS    = 18;
  localparam int CNT_BITS    = 11;
  localparam int DIFF_BITS   = 31;

  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_TDATA_BITS = 64;

  localparam logic [BL_BITS-1:0] BL_RESET = 10'd200;
  localparam logic [WS_BITS-1:0] WS_RESET = 10'd400;
  localparam logic [WE_BITS-1:0] WE_RESET = 11'd900;

  localparam logic signed [DIFF_BITS-1:0] CHG_CEIL  = 31'sd268435455;
  localparam logic signed [DIFF_BITS-1:0] CHG_FLOOR = -31'sd268435456;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BASELINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_START    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_END      = 2'd2;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;       // sample transfer this cycle
    logic div_start;  // latch end-of-waveform figures, start divider
    logic mul_en;     // register product and amplitude
    logic out_load;   // load result register, clear accumulators
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/pcae_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pcae_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pcae_pkg::NUM_BITS-1:0] num,
  input  wire logic [pcae_pkg::BL_BITS-1:0]  den,
  output logic                               done,
  output logic [pcae_pkg::NUM_BITS-1:0]      quot
);

  localparam int CNT_W = $clog2(pcae_pkg::NUM_BITS + 1);
  localparam int DW    = pcae_pkg::BL_BITS;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_q;
  logic [DW:0]      rem_shift;
  logic [DW+1:0]    trial;

  assign rem_shift = {rem, quot[pcae_pkg::NUM_BITS-1]};
  assign trial     = {1'b0, rem_shift} - {2'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(pcae_pkg::NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      // keep the trial remainder when it does not borrow
      if (!trial[DW+1]) begin
        rem  <= trial[DW-1:0];
        quot <= {quot[pcae_pkg::NUM_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[DW-1:0];
        quot <= {quot[pcae_pkg::NUM_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcae_datapath.sv =====
// Datapath: configuration, per-sample accumulators, divider, product and result register.
`timescale 1ns / 1ps
`default_nettype none

module pcae_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pcae_pkg::cmd_t                       cmd,
  output pcae_pkg::sts_t                            sts,
  input  wire logic                                 cfg_we,
  input  wire logic [pcae_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [pcae_pkg::CFG_BITS-1:0]        cfg_data,
  input  wire logic [pcae_pkg::SAMPLE_BITS-1:0]     sample,
  output logic signed [pcae_pkg::CHARGE_BITS-1:0]   charge_q4,
  output logic [pcae_pkg::AMP_BITS-1:0]             amplitude_q4,
  output logic [pcae_pkg::CNT_BITS-1:0]             sample_count,
  output logic                                      short_waveform
);

  logic [pcae_pkg::BL_BITS-1:0]     bl_len;
  logic [pcae_pkg::WS_BITS-1:0]     win_start;
  logic [pcae_pkg::WE_BITS-1:0]     win_end;

  logic [pcae_pkg::IDX_BITS-1:0]    idx;
  logic [pcae_pkg::SUM_BITS-1:0]    bsum;
  logic [pcae_pkg::SUM_BITS-1:0]    wsum;
  logic [pcae_pkg::SAMPLE_BITS-1:0] minv;

  logic [pcae_pkg::IDX_BITS-1:0]    ws_ext;
  logic [pcae_pkg::IDX_BITS-1:0]    bl_ext;
  logic [pcae_pkg::BL_BITS-1:0]     nb;
  logic [pcae_pkg::IDX_BITS-1:0]    hi;
  logic [pcae_pkg::IDX_BITS-1:0]    len_next;

  logic [pcae_pkg::IDX_BITS-1:0]    len;
  logic                             nb_zero;
  logic [pcae_pkg::IDX_BITS-1:0]    count;
  logic                             short_q;

  logic                             div_done;
  logic [pcae_pkg::NUM_BITS-1:0]    quot;
  logic [pcae_pkg::BASE_BITS-1:0]   base;
  logic [pcae_pkg::BASE_BITS:0]     amp_diff;
  logic [pcae_pkg::CHARGE_BITS-1:0] prod;
  logic [pcae_pkg::AMP_BITS-1:0]    amp;
  logic signed [pcae_pkg::DIFF_BITS-1:0] charge_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      bl_len    <= pcae_pkg::BL_RESET;
      win_start <= pcae_pkg::WS_RESET;
      win_end   <= pcae_pkg::WE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcae_pkg::CFG_BASELINE_LENGTH: bl_len    <= cfg_data[pcae_pkg::BL_BITS-1:0];
        pcae_pkg::CFG_WINDOW_START:    win_start <= cfg_data[pcae_pkg::WS_BITS-1:0];
        pcae_pkg::CFG_WINDOW_END:      win_end   <= cfg_data[pcae_pkg::WE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ws_ext = {1'b0, win_start};
  assign bl_ext = {1'b0, bl_len};

  // accumulate while the waveform runs; drop samples past the buffer limit
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      idx  <= '0;
      bsum <= '0;
      wsum <= '0;
      minv <= '1;
    end else if (cmd.take && (idx < pcae_pkg::IDX_BITS'(pcae_pkg::MAX_SAMPLES))) begin
      if (idx < bl_ext) bsum <= bsum + pcae_pkg::SUM_BITS'(sample);
      if (idx >= ws_ext && idx < win_end) wsum <= wsum + pcae_pkg::SUM_BITS'(sample);
      if (sample < minv) minv <= sample;
      idx <= idx + 1'b1;
    end
  end

  always_comb begin
    nb       = (bl_ext < idx) ? bl_len : idx[pcae_pkg::BL_BITS-1:0];
    hi       = (win_end < idx) ? win_end : idx;
    len_next = (hi > ws_ext) ? hi - ws_ext : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      len     <= len_next;
      nb_zero <= (nb == '0);
      count   <= idx;
      short_q <= (idx < win_end) || (idx < bl_ext);
    end
  end

  pcae_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  ({bsum, pcae_pkg::FRAC_BITS'(0)}),
    .den  (nb),
    .done (div_done),
    .quot (quot)
  );

  assign sts.div_done = div_done;

  assign base     = nb_zero ? '0 : quot[pcae_pkg::BASE_BITS-1:0];
  assign amp_diff = {1'b0, base} - {1'b0, minv, pcae_pkg::FRAC_BITS'(0)};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= pcae_pkg::CHARGE_BITS'(len) * pcae_pkg::CHARGE_BITS'(base);
      amp  <= amp_diff[pcae_pkg::BASE_BITS] ? '0 : amp_diff[pcae_pkg::AMP_BITS-1:0];
    end
  end

  assign charge_full = $signed({2'b0, prod}) - $signed({3'b0, wsum, pcae_pkg::FRAC_BITS'(0)});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (charge_full > pcae_pkg::CHG_CEIL) begin
        charge_q4 <= pcae_pkg::CHARGE_BITS'(pcae_pkg::CHG_CEIL);
      end else if (charge_full < pcae_pkg::CHG_FLOOR) begin
        charge_q4 <= pcae_pkg::CHARGE_BITS'(pcae_pkg::CHG_FLOOR);
      end else begin
        charge_q4 <= charge_full[pcae_pkg::CHARGE_BITS-1:0];
      end
      amplitude_q4   <= amp;
      sample_count   <= count;
      short_waveform <= short_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcae_ctrl.sv =====
// Controller: waveform state machine and stream handshakes.
`timescale 1ns / 1ps
`default_nettype none

module pcae_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  input  wire logic           s_tlast,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  input  wire pcae_pkg::sts_t sts,
  output pcae_pkg::cmd_t      cmd
);

  pcae_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pcae_pkg::ST_ACC;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcae_pkg::ST_ACC:   if (s_tvalid && s_tlast) state_next = pcae_pkg::ST_START;
      pcae_pkg::ST_START: state_next = pcae_pkg::ST_DIV;
      pcae_pkg::ST_DIV:   if (sts.div_done) state_next = pcae_pkg::ST_MUL;
      pcae_pkg::ST_MUL:   state_next = pcae_pkg::ST_OUT;
      pcae_pkg::ST_OUT:   if (!m_tvalid || m_tready) state_next = pcae_pkg::ST_ACC;
      default:            state_next = pcae_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    unique case (state)
      pcae_pkg::ST_ACC: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      pcae_pkg::ST_START: cmd.div_start = 1'b1;
      pcae_pkg::ST_DIV:   ;
      pcae_pkg::ST_MUL:   cmd.mul_en = 1'b1;
      pcae_pkg::ST_OUT:   cmd.out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (rst)               m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready)     m_tvalid <= 1'b0;
  end

endmodule

`default_nettype wire

// ===== rtl/pulse_charge_amplitude_extractor.sv =====
// Top level of the pulse charge and amplitude extractor.
// Samples of a waveform are taken one per cycle.
// After the last sample the input stalls while the restoring divider forms the baseline
// mean, one bit per cycle, and while setup, the divider's finishing step, the product and
// the result register complete. A result still waiting downstream does not block the
// next waveform's samples, but stretches that waveform's end stall until it transfers.
// Synchronous reset clears the control state and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module pulse_charge_amplitude_extractor (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [pcae_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // sample
  input  wire logic                                  s_tlast,   // last_sample
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [pcae_pkg::OUT_TDATA_BITS-1:0]        m_tdata,   // charge_q4, amplitude_q4, sample_count
  output logic [0:0]                                 m_tuser,   // short_waveform
  input  wire logic                                  cfg_we,
  input  wire logic [pcae_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [pcae_pkg::CFG_BITS-1:0]         cfg_data
);

  pcae_pkg::cmd_t cmd;
  pcae_pkg::sts_t sts;

  logic signed [pcae_pkg::CHARGE_BITS-1:0] charge_q4;
  logic [pcae_pkg::AMP_BITS-1:0]           amplitude_q4;
  logic [pcae_pkg::CNT_BITS-1:0]           sample_count;
  logic                                    short_waveform;

  pcae_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tlast (s_tlast),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pcae_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (s_tdata[pcae_pkg::SAMPLE_BITS-1:0]),
    .charge_q4     (charge_q4),
    .amplitude_q4  (amplitude_q4),
    .sample_count  (sample_count),
    .short_waveform(short_waveform)
  );

  assign m_tdata = {6'b0, sample_count, amplitude_q4, charge_q4};
  assign m_tuser = short_waveform;

endmodule

`default_nettype wire

// ===== rtl/pcae_checker.sv =====
// Port-level checker for the pulse charge and amplitude extractor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [10:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // the end of a waveform stops sample transfers while the result is formed
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input not stalled after last sample");

  // a result becomes valid only out of the stalled phase
  a_rose_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without end-of-waveform processing");

  // a waveform always carries between one and the maximum number of samples
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[57:47] != 11'd0) && (m_tdata[57:47] <= 11'd1024))
    else $error("sample count out of range");

endmodule

bind pulse_charge_amplitude_extractor pcae_checker u_pcae_checker (.*);

`default_nettype wire
